>>> sv/ddo_pkg.sv
`timescale 1ns / 1ps

package ddo_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int CORDIC_ITERS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int CORDIC_SHIFT     = 30 - FRAC_BITS;

  localparam longint Q30_PI   = 64'd3373259426;
  localparam longint Q30_GAIN = 64'd652032874;
  localparam longint PI_Q     = (Q30_PI + (64'd1 << (29 - FRAC_BITS))) >> CORDIC_SHIFT;
  localparam longint TWO_PI_Q = 2 * PI_Q;
  localparam longint HALF_PI_Q = PI_Q / 2;

  localparam logic [20:0] RATE_SCALE = 21'd1000000;

  localparam logic [15:0] RADIUS_RESET = 16'd3277;
  localparam logic [17:0] BASE_RESET   = 18'd19661;

  // divider geometry: dividend up to 72 bits, divisor up to 34 bits
  localparam int DIV_W  = 72;
  localparam int DIVR_W = 34;

  typedef enum logic {
    REG_WHEEL_RADIUS = 1'b0,
    REG_WHEEL_BASE   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [18:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [17:0] sin_v;
    logic signed [17:0] cos_v;
  } cordic_rsp_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/differential_drive_odometry.sv
`timescale 1ns / 1ps

// Differential-drive wheel odometry, Q16.16.
// Input stream s_*: one word per encoder sample (wheel angles, yaw, time).
// Output stream m_*: one word per input word with the updated pose, the
// wheel rates, linear speed and yaw rate; m_tuser flags a zero time step,
// in which case all rates read zero while the pose still advances.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 wheel radius, 1 wheel base); write only while the block is idle.
// One word is in flight at a time: s_tready is high only in the idle state.
// The 72-step restoring divider runs once for the turn angle and once for
// each of the four rates; with a zero time step the divider is skipped and
// the result goes straight to the output. The CORDIC overlaps the travel math.
// The result sits in an output register; when the receiver stalls, the next
// word is still accepted and processed, and its result waits to be loaded.
// Synchronous reset clears the pose, previous samples and output valid, and
// restores the default radius and base.
module differential_drive_odometry #(
  parameter int CORDIC_ITERS = ddo_pkg::CORDIC_ITERS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [17:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // left_angle[31:0], right_angle[63:32], heading[82:64], time_us[114:83]
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x[31:0], pos_y[63:32], linear_speed[95:64], turn_rate[127:96],
  // left_rate[159:128], right_rate[191:160]
  output logic [191:0] m_tdata,
  // zero_interval[0]
  output logic         m_tuser
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_ML    = 15'b000000000000010,
    S_MR    = 15'b000000000000100,
    S_SUM   = 15'b000000000001000,
    S_WAITC = 15'b000000000010000,
    S_PX    = 15'b000000000100000,
    S_PY    = 15'b000000001000000,
    S_PYW   = 15'b000000010000000,
    S_TH    = 15'b000000100000000,
    S_THW   = 15'b000001000000000,
    S_RH    = 15'b000010000000000,
    S_RL    = 15'b000100000000000,
    S_RD    = 15'b001000000000000,
    S_RW    = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state;

  logic [15:0] radius;
  logic [17:0] base;
  logic [31:0] prev_left, prev_right, prev_time, pose_x, pose_y, dt;
  logic signed [32:0] dl, dr, tl, tr_v;
  logic signed [33:0] sum, diff;
  logic signed [50:0] dth;
  logic [1:0]  k;
  logic [71:0] acc;
  logic signed [31:0] rates [4];
  logic        zero_flag;

  logic signed [34:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [55:0] prod;

  logic signed [51:0] sv;
  logic [51:0] mag;
  logic [33:0] diff_mag;
  logic [31:0] rate_sat;
  logic        accept;

  ddo_pkg::div_req_t    div_req;
  ddo_pkg::div_rsp_t    div_rsp;
  ddo_pkg::cordic_req_t cor_req;
  ddo_pkg::cordic_rsp_t cor_rsp;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign cor_req.start = accept;
  assign cor_req.angle = signed'(s_tdata[82:64]);

  ddo_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cor_req),
    .rsp (cor_rsp)
  );

  ddo_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // operand select for the shared multiplier
  always_comb begin
    unique case (k)
      2'd0: sv = {{19{dl[32]}}, dl};
      2'd1: sv = {{19{dr[32]}}, dr};
      2'd2: sv = {{18{sum[33]}}, sum};
      2'd3: sv = {dth[50], dth};
      default: sv = '0;
    endcase
    mag      = sv[51] ? 52'(-sv) : 52'(sv);
    diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
    tr_v     = 33'(prod >>> ddo_pkg::FRAC_BITS);

    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_ML: begin
        mul_a = {{2{dl[32]}}, dl};
        mul_b = {5'b0, radius};
      end
      S_MR: begin
        mul_a = {{2{dr[32]}}, dr};
        mul_b = {5'b0, radius};
      end
      S_PX: begin
        mul_a = {sum[33], sum};
        mul_b = {{3{cor_rsp.cos_v[17]}}, cor_rsp.cos_v};
      end
      S_PY: begin
        mul_a = {sum[33], sum};
        mul_b = {{3{cor_rsp.sin_v[17]}}, cor_rsp.sin_v};
      end
      S_RH: begin
        mul_a = {9'b0, mag[50:25]};
        mul_b = signed'(ddo_pkg::RATE_SCALE);
      end
      S_RL: begin
        mul_a = {10'b0, mag[24:0]};
        mul_b = signed'(ddo_pkg::RATE_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    div_req.start    = 1'b0;
    div_req.dividend = {{22{1'b0}}, diff_mag, {ddo_pkg::FRAC_BITS{1'b0}}};
    div_req.divisor  = (base == '0) ? ddo_pkg::DIVR_W'(1) : {16'b0, base};
    if (state == S_TH) begin
      div_req.start = 1'b1;
    end else if (state == S_RD) begin
      div_req.start    = 1'b1;
      div_req.dividend = acc + {16'b0, prod};
      div_req.divisor  = (k == 2'd2) ? {1'b0, dt, 1'b0} : {2'b0, dt};
    end

    // saturate the rate magnitude and restore its sign
    if (sv[51]) begin
      rate_sat = (div_rsp.quotient > 72'h80000000) ? 32'h80000000
                                                   : 32'(-div_rsp.quotient);
    end else begin
      rate_sat = (div_rsp.quotient > 72'h7fffffff) ? 32'h7fffffff
                                                   : div_rsp.quotient[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      radius     <= ddo_pkg::RADIUS_RESET;
      base       <= ddo_pkg::BASE_RESET;
      prev_left  <= '0;
      prev_right <= '0;
      prev_time  <= '0;
      pose_x     <= '0;
      pose_y     <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (ddo_pkg::reg_index_t'(cfg_index))
          ddo_pkg::REG_WHEEL_RADIUS: radius <= cfg_data[15:0];
          ddo_pkg::REG_WHEEL_BASE:   base   <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            dl <= signed'({s_tdata[31], s_tdata[31:0]}) -
                  signed'({prev_left[31], prev_left});
            dr <= signed'({s_tdata[63], s_tdata[63:32]}) -
                  signed'({prev_right[31], prev_right});
            dt <= s_tdata[114:83] - prev_time;
            prev_left  <= s_tdata[31:0];
            prev_right <= s_tdata[63:32];
            prev_time  <= s_tdata[114:83];
            state      <= S_ML;
          end
        end
        S_ML:  state <= S_MR;
        S_MR: begin
          tl    <= tr_v;
          state <= S_SUM;
        end
        S_SUM: begin
          sum   <= {tl[32], tl} + {tr_v[32], tr_v};
          diff  <= {tr_v[32], tr_v} - {tl[32], tl};
          state <= S_WAITC;
        end
        S_WAITC: begin
          if (cor_rsp.done) state <= S_PX;
        end
        S_PX: state <= S_PY;
        S_PY: begin
          pose_x <= pose_x + 32'(prod >>> (ddo_pkg::FRAC_BITS + 1));
          state  <= S_PYW;
        end
        S_PYW: begin
          pose_y <= pose_y + 32'(prod >>> (ddo_pkg::FRAC_BITS + 1));
          k      <= '0;
          if (dt == '0) begin
            zero_flag <= 1'b1;
            rates[0]  <= '0;
            rates[1]  <= '0;
            rates[2]  <= '0;
            rates[3]  <= '0;
            state     <= S_OUT;
          end else begin
            zero_flag <= 1'b0;
            state     <= S_TH;
          end
        end
        S_TH: state <= S_THW;
        S_THW: begin
          if (div_rsp.done) begin
            dth   <= diff[33] ? 51'(-div_rsp.quotient) : 51'(div_rsp.quotient);
            state <= S_RH;
          end
        end
        S_RH: state <= S_RL;
        S_RL: begin
          acc   <= {16'b0, prod} << 25;
          state <= S_RD;
        end
        S_RD: state <= S_RW;
        S_RW: begin
          if (div_rsp.done) begin
            rates[k] <= rate_sat;
            k        <= k + 1'b1;
            state    <= (k == 2'd3) ? S_OUT : S_RH;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            // rates[2] = linear speed, rates[3] = turn rate
            m_tdata  <= {rates[1], rates[0], rates[3], rates[2], pose_y, pose_x};
            m_tuser  <= zero_flag;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ddo_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, unsigned.
module ddo_divider (
  input  logic              clk,
  input  logic              rst,
  input  ddo_pkg::div_req_t req,
  output ddo_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(ddo_pkg::DIV_W);

  logic [ddo_pkg::DIVR_W-1:0] rem, rem_next, dvs;
  logic [ddo_pkg::DIVR_W:0]   rem_sh;
  logic [ddo_pkg::DIV_W-1:0]  quo;
  logic [CNT_W-1:0]           cnt;
  logic                       busy, done, take;

  always_comb begin
    rem_sh   = {rem, quo[ddo_pkg::DIV_W-1]};
    take     = rem_sh >= {1'b0, dvs};
    rem_next = take ? ddo_pkg::DIVR_W'(rem_sh - {1'b0, dvs}) : rem_sh[ddo_pkg::DIVR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvs  <= req.divisor;
      cnt  <= CNT_W'(ddo_pkg::DIV_W - 1);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[ddo_pkg::DIV_W-2:0], take};
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> sv/ddo_cordic.sv
`timescale 1ns / 1ps

// Rotation-mode CORDIC in Q30, one micro-rotation per cycle.
module ddo_cordic #(
  parameter int ITERS = ddo_pkg::CORDIC_ITERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ddo_pkg::cordic_req_t req,
  output ddo_pkg::cordic_rsp_t rsp
);

  localparam int IDX_W = $clog2(ITERS);
  localparam logic signed [20:0] PI_V   = 21'(ddo_pkg::PI_Q);
  localparam logic signed [20:0] TWO_PI = 21'(ddo_pkg::TWO_PI_Q);
  localparam logic signed [20:0] HALF   = 21'(ddo_pkg::HALF_PI_Q);

  logic signed [33:0] x, y, z, xs, ys, at, z0, xq, yq;
  logic signed [20:0] a0, a1, a2;
  logic               neg, neg0, busy, done;
  logic [IDX_W-1:0]   idx;

  // reduce into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    a0   = {{2{req.angle[18]}}, req.angle};
    if (a0 > PI_V)       a1 = a0 - TWO_PI;
    else if (a0 < -PI_V) a1 = a0 + TWO_PI;
    else                 a1 = a0;
    neg0 = 1'b1;
    if (a1 > HALF)       a2 = a1 - PI_V;
    else if (a1 < -HALF) a2 = a1 + PI_V;
    else begin
      a2   = a1;
      neg0 = 1'b0;
    end
    z0 = {{13{a2[20]}}, a2} <<< ddo_pkg::CORDIC_SHIFT;
  end

  always_comb begin
    xs = x >>> idx;
    ys = y >>> idx;
    at = signed'({4'b0, ddo_pkg::atan_q30(5'(idx))});
    xq = x >>> ddo_pkg::CORDIC_SHIFT;
    yq = y >>> ddo_pkg::CORDIC_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      x    <= 34'(ddo_pkg::Q30_GAIN);
      y    <= '0;
      z    <= z0;
      neg  <= neg0;
      idx  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      if (idx == IDX_W'(ITERS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.cos_v = neg ? 18'(-xq) : 18'(xq);
  assign rsp.sin_v = neg ? 18'(-yq) : 18'(yq);

endmodule

>>> sv/ddo_checker.sv
`timescale 1ns / 1ps

module ddo_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata,
  input logic         m_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // zero time step forces every rate to zero
  a_zero_rates: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[191:64] == '0)
    else $error("rates nonzero with zero interval");

  // reset drops any pending result
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);

>>> test/tb_differential_drive_odometry.sv
`timescale 1ns / 1ps

module tb_differential_drive_odometry;

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
    logic [18:0] heading;
    logic [31:0] time_us;
  } sample_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] lin;
    logic [31:0] turn;
    logic [31:0] lrate;
    logic [31:0] rrate;
    logic        zero_dt;
  } odo_t;

  typedef struct {
    sample_t s;
    bit      typed;
    odo_t    res;
  } vec_t;

  localparam longint PI_F   = (64'd3373259426 + (64'd1 << 13)) >>> 14;
  localparam longint TWOPI_F = 2 * PI_F;
  localparam longint HALFPI_F = PI_F / 2;
  localparam longint GAIN_Q30 = 64'd652032874;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [17:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;
  logic         m_tuser;

  // predictor copy of the block state
  logic [15:0] radius;
  logic [17:0] base_len;
  logic [31:0] last_left, last_right, last_time, pose_x, pose_y;

  longint atan_tab [16];
  odo_t   pending_q [$];
  vec_t   vecs [$];
  int     errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_zero = 0;
  bit     quiet = 1'b0;
  bit     hold_req = 1'b0;

  differential_drive_odometry dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint shift_floor(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic logic [31:0] per_sec(longint num, longint d);
    longint q, r, v;
    q = num / d;
    r = num % d;
    if (q > 3000) return 32'h7fffffff;
    if (q < -3000) return 32'h80000000;
    v = q * 1000000 + (r * 1000000) / d;
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[31:0];
  endfunction

  task automatic heading_trig(input longint ang_in, output longint sn, output longint cs);
    longint ang, x, y, z, xs, ys;
    bit flip;
    ang = ang_in % TWOPI_F;
    flip = 1'b0;
    if (ang > PI_F) ang -= TWOPI_F;
    if (ang < -PI_F) ang += TWOPI_F;
    if (ang > HALFPI_F) begin
      ang -= PI_F; flip = 1'b1;
    end else if (ang < -HALFPI_F) begin
      ang += PI_F; flip = 1'b1;
    end
    x = GAIN_Q30;
    y = 0;
    z = ang * (64'sd1 << 14);
    for (int i = 0; i < 16; i++) begin
      xs = shift_floor(x, i);
      ys = shift_floor(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    x = shift_floor(x, 14);
    y = shift_floor(y, 14);
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  task automatic odometry_step(input sample_t s, output odo_t o);
    longint dt, dl, dr, tl, tr, sum, bl, dth, sn, cs, stepx, stepy;
    logic [31:0] dt32;
    dt32 = s.time_us - last_time;
    dt = longint'({32'd0, dt32});
    dl = longint'($signed(s.left)) - longint'($signed(last_left));
    dr = longint'($signed(s.right)) - longint'($signed(last_right));
    tl = shift_floor(dl * longint'({48'd0, radius}), 16);
    tr = shift_floor(dr * longint'({48'd0, radius}), 16);
    sum = tl + tr;
    bl = (base_len == 0) ? 1 : longint'({46'd0, base_len});
    o.lin = '0; o.turn = '0; o.lrate = '0; o.rrate = '0; o.zero_dt = 1'b1;
    if (dt != 0) begin
      dth = ((tr - tl) * (64'sd1 << 16)) / bl;
      o.lrate = per_sec(dl, dt);
      o.rrate = per_sec(dr, dt);
      o.lin = per_sec(sum, 2 * dt);
      o.turn = per_sec(dth, dt);
      o.zero_dt = 1'b0;
    end
    heading_trig(longint'($signed(s.heading)), sn, cs);
    stepx = shift_floor(sum * cs, 17);
    stepy = shift_floor(sum * sn, 17);
    pose_x = pose_x + stepx[31:0];
    pose_y = pose_y + stepy[31:0];
    last_left = s.left;
    last_right = s.right;
    last_time = s.time_us;
    o.pos_x = pose_x;
    o.pos_y = pose_y;
  endtask

  task automatic send_word(input vec_t v);
    odo_t o;
    int gap;
    s_tdata <= {5'd0, v.s.time_us, v.s.heading, v.s.right, v.s.left};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    odometry_step(v.s, o);
    pending_q.push_back(v.typed ? v.res : o);
    n_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [17:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == 1'b0) radius = val[15:0];
    else base_len = val;
    @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic vec_t mk(logic [31:0] l, logic [31:0] r, logic [18:0] h,
                              logic [31:0] t);
    vec_t v;
    v.s.left = l; v.s.right = r; v.s.heading = h; v.s.time_us = t;
    v.typed = 1'b0;
    v.res = '{default: '0};
    return v;
  endfunction

  function automatic vec_t random_word();
    logic [31:0] l, r, t;
    logic [18:0] h;
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      // plausible motion: small deltas, short steps
      l = last_left + 32'($signed($urandom_range(0, 200000)) - 100000);
      r = last_right + 32'($signed($urandom_range(0, 200000)) - 100000);
      t = last_time + $urandom_range(1, 50000);
    end else begin
      l = $urandom;
      r = $urandom;
      t = (k == 7) ? $urandom : last_time + $urandom_range(0, 3);
    end
    if ($urandom_range(0, 9) == 0) t = last_time;
    if ($urandom_range(0, 7) == 0) h = 19'($urandom);
    else h = 19'($signed($urandom_range(0, 411776)) - 205888);
    return mk(l, r, h, t);
  endfunction

  // receiver: random stalls, one long hold-off on request, checking
  initial begin
    odo_t e;
    odo_t got;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.pos_x = m_tdata[31:0];
        got.pos_y = m_tdata[63:32];
        got.lin = m_tdata[95:64];
        got.turn = m_tdata[127:96];
        got.lrate = m_tdata[159:128];
        got.rrate = m_tdata[191:160];
        got.zero_dt = m_tuser;
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: %p", got);
        end else begin
          e = pending_q.pop_front();
          n_checked++;
          if (got.zero_dt) n_zero++;
          if (got !== e) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", e, got);
          end
        end
      end
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    vec_t v;
    logic [15:0] radii [5];
    logic [17:0] bases [5];
    atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                 262143, 131071, 65535, 32767};
    radius = 16'd3277;
    base_len = 18'd19661;
    last_left = '0; last_right = '0; last_time = '0; pose_x = '0; pose_y = '0;

    // first word after reset with zero time: nothing moves, zero step flagged
    v = mk(32'd0, 32'd0, 19'd0, 32'd0);
    v.typed = 1'b1;
    v.res.zero_dt = 1'b1;
    vecs.push_back(v);
    vecs.push_back(mk(32'd65536, 32'd65536, 19'd0, 32'd10000));
    vecs.push_back(mk(32'h7fffffff, 32'h80000000, 19'd205888, 32'd10001));
    vecs.push_back(mk(32'h80000000, 32'h7fffffff, -19'sd205888, 32'd10002));
    vecs.push_back(mk(32'h7fffffff, 32'h7fffffff, 19'h3ffff, 32'd10002));
    vecs.push_back(mk(32'h80000000, 32'h80000000, 19'h40000, 32'hffffffff));
    vecs.push_back(mk(32'h00010000, 32'hfffe0000, 19'd102944, 32'd5));
    vecs.push_back(mk(32'h00020000, 32'hfffd0000, -19'sd102944, 32'd1005));
    vecs.push_back(mk(32'h00030000, 32'hfffd0000, 19'h7ffff, 32'd1005));
    vecs.push_back(mk(32'h00030000, 32'h00030000, 19'd205887, 32'd80000));
    vecs.push_back(mk(32'hffffffff, 32'h00000001, 19'd1, 32'd80000000));
    vecs.push_back(mk(32'h55555555, 32'haaaaaaaa, 19'h2aaaa, 32'h55555555));
    vecs.push_back(mk(32'haaaaaaaa, 32'h55555555, 19'h55555, 32'haaaaaaaa));

    radii = '{16'd3277, 16'd65535, 16'd1, 16'd0, 16'd0};
    bases = '{18'd19661, 18'd262143, 18'd1, 18'd0, 18'd0};
    radii[4] = 16'($urandom_range(1, 65535));
    bases[4] = 18'($urandom_range(1, 262143));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vecs[i]) send_word(vecs[i]);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(1'b0, {2'b00, radii[p]});
      write_reg(1'b1, bases[p]);
      for (int i = 0; i < 160; i++) begin
        if (p == 1 && i == 20) hold_req = 1'b1;
        if (p == 4 && i == 60) quiet = 1'b1;
        send_word(random_word());
      end
      drain();
    end

    repeat (450) @(posedge clk);
    $display("sent %0d words over 5 wheel settings, checked %0d results (%0d zero-step)",
             n_sent, n_checked, n_zero);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ddo_pkg.sv
sv/ddo_divider.sv
sv/ddo_cordic.sv
sv/differential_drive_odometry.sv
sv/ddo_checker.sv
test/tb_differential_drive_odometry.sv
